// ===== rtl/dpc_pkg.sv =====
// ---------------------------------------------------------------------------
// dpc_pkg
// Shared widths, limits and the frame record passed from the front end to
// the divider for the dark pixel centroid core.
// ---------------------------------------------------------------------------
package dpc_pkg;

   localparam int MaxWidth  = 2048;
   localparam int MaxHeight = 2048;

   localparam int ColWidth   = $clog2(MaxWidth);
   localparam int RowWidth   = $clog2(MaxHeight);
   localparam int CoordWidth = 11;
   localparam int PixWidth   = 8;
   localparam int ThrWidth   = 10;
   localparam int TallyWidth = 23;
   localparam int SumWidth   = 33;

   localparam logic [ThrWidth-1:0]   ThreshReset = ThrWidth'(3 * 80);
   localparam logic [TallyWidth-1:0] TallyMax    = {TallyWidth{1'b1}};
   localparam logic [SumWidth-1:0]   SumMax      = {SumWidth{1'b1}};
   localparam logic [ColWidth-1:0]   ColLast     = ColWidth'(MaxWidth - 1);
   localparam logic [RowWidth-1:0]   RowLast     = RowWidth'(MaxHeight - 1);
   localparam logic [CoordWidth-1:0] CoordMax    = {CoordWidth{1'b1}};

   // one restoring step per bit of the dividend
   localparam int DivSteps   = SumWidth;
   localparam int StepWidth  = $clog2(DivSteps);

   typedef struct packed {
      logic [SumWidth-1:0]   col_sum;
      logic [SumWidth-1:0]   row_sum;
      logic [TallyWidth-1:0] hit_count;
   } frame_rec_type;

endpackage

// ===== rtl/dpc_front.sv =====
// ---------------------------------------------------------------------------
// dpc_front
// Pixel front end: threshold compare, raster position tracking and
// saturating accumulation; pushes one frame record per frame end.
// ---------------------------------------------------------------------------
module dpc_front
   import dpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [ThrWidth-1:0]   csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PixWidth-1:0]   req_blue,
   input  logic [PixWidth-1:0]   req_green,
   input  logic [PixWidth-1:0]   req_red,
   input  logic                  req_line_end,
   input  logic                  req_frame_end,
   input  logic                  q_full,
   output logic                  q_push,
   output frame_rec_type         q_rec
);

   logic [ThrWidth-1:0]   thr_ff,   thr_in;
   logic [ColWidth-1:0]   col_ff,   col_in;
   logic [RowWidth-1:0]   row_ff,   row_in;
   logic [TallyWidth-1:0] tally_ff, tally_in;
   logic [SumWidth-1:0]   csum_ff,  csum_in;
   logic [SumWidth-1:0]   rsum_ff,  rsum_in;

   logic                  accept;
   logic [ThrWidth-1:0]   pix_sum;
   logic                  hit;
   logic [SumWidth:0]     csum_add, rsum_add;
   logic [TallyWidth-1:0] tally_upd;
   logic [SumWidth-1:0]   csum_upd, rsum_upd;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   assign pix_sum = ThrWidth'(req_blue) + ThrWidth'(req_green) + ThrWidth'(req_red);
   assign hit     = pix_sum < thr_ff;

   assign csum_add = {1'b0, csum_ff} + (SumWidth + 1)'(col_ff);
   assign rsum_add = {1'b0, rsum_ff} + (SumWidth + 1)'(row_ff);

   always_comb begin
      tally_upd = tally_ff;
      csum_upd  = csum_ff;
      rsum_upd  = rsum_ff;
      if (hit) begin
         tally_upd = (tally_ff == TallyMax) ? TallyMax : tally_ff + 1'b1;
         csum_upd  = csum_add[SumWidth] ? SumMax : csum_add[SumWidth-1:0];
         rsum_upd  = rsum_add[SumWidth] ? SumMax : rsum_add[SumWidth-1:0];
      end
   end

   // an empty frame reports a count of one
   assign q_push            = accept && req_frame_end;
   assign q_rec.col_sum     = csum_upd;
   assign q_rec.row_sum     = rsum_upd;
   assign q_rec.hit_count   = (tally_upd == '0) ? TallyWidth'(1) : tally_upd;

   always_comb begin
      thr_in   = csr_write_enable ? csr_write_data : thr_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      tally_in = tally_ff;
      csum_in  = csum_ff;
      rsum_in  = rsum_ff;
      if (accept) begin
         if (req_frame_end) begin
            col_in   = '0;
            row_in   = '0;
            tally_in = '0;
            csum_in  = '0;
            rsum_in  = '0;
         end else begin
            tally_in = tally_upd;
            csum_in  = csum_upd;
            rsum_in  = rsum_upd;
            if (req_line_end) begin
               col_in = '0;
               if (row_ff != RowLast) begin
                  row_in = row_ff + 1'b1;
               end
            end else if (col_ff != ColLast) begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= ThreshReset;
         col_ff   <= '0;
         row_ff   <= '0;
         tally_ff <= '0;
         csum_ff  <= '0;
         rsum_ff  <= '0;
      end else begin
         thr_ff   <= thr_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         tally_ff <= tally_in;
         csum_ff  <= csum_in;
         rsum_ff  <= rsum_in;
      end
   end

endmodule

// ===== rtl/dpc_queue.sv =====
// ---------------------------------------------------------------------------
// dpc_queue
// Two-entry queue of frame records between the front end and the divider.
// ---------------------------------------------------------------------------
module dpc_queue
   import dpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  frame_rec_type push_rec,
   output logic          full,
   output logic          pop_valid,
   input  logic          pop,
   output frame_rec_type pop_rec
);

   frame_rec_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff,  count_in;
   logic          do_push, do_pop;

   assign full      = count_ff == 2'd2;
   assign pop_valid = count_ff != 2'd0;
   assign pop_rec   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   // a word pushed while full would be lost
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("dpc_queue: push while full");

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("dpc_queue: count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("dpc_queue: pointers disagree with count");

endmodule

// ===== rtl/dpc_divider.sv =====
// ---------------------------------------------------------------------------
// dpc_divider
// Back end: two restoring dividers sharing one divisor, one quotient bit
// per cycle, with clamp to the coordinate range and an output register.
// ---------------------------------------------------------------------------
module dpc_divider
   import dpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  frame_rec_type         q_rec,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CoordWidth-1:0] rsp_centroid_x,
   output logic [CoordWidth-1:0] rsp_centroid_y,
   output logic [TallyWidth-1:0] rsp_hit_count
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StRun  = 2'd1;
   localparam logic [1:0] StDone = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [StepWidth-1:0]  step_ff,  step_in;
   logic                  out_valid_ff, out_valid_in;

   logic [TallyWidth-1:0] div_ff;
   logic [SumWidth-1:0]   qx_ff, qy_ff;
   logic [TallyWidth-1:0] rx_ff, ry_ff;
   logic [CoordWidth-1:0] ox_ff, oy_ff;
   logic [TallyWidth-1:0] on_ff;

   logic [TallyWidth:0]   trial_x, trial_y;
   logic                  bit_x, bit_y;
   logic [TallyWidth-1:0] rem_x, rem_y;
   logic                  load_out;
   logic [CoordWidth-1:0] clamp_x, clamp_y;

   assign q_pop    = (state_ff == StIdle) && q_valid;
   assign load_out = (state_ff == StDone) && (!out_valid_ff || rsp_ready);

   // restoring step: shift in the next dividend bit, subtract if it fits
   assign trial_x = {rx_ff, qx_ff[SumWidth-1]};
   assign trial_y = {ry_ff, qy_ff[SumWidth-1]};
   assign bit_x   = trial_x >= {1'b0, div_ff};
   assign bit_y   = trial_y >= {1'b0, div_ff};
   assign rem_x   = bit_x ? TallyWidth'(trial_x - {1'b0, div_ff}) : trial_x[TallyWidth-1:0];
   assign rem_y   = bit_y ? TallyWidth'(trial_y - {1'b0, div_ff}) : trial_y[TallyWidth-1:0];

   assign clamp_x = (qx_ff[SumWidth-1:CoordWidth] != '0) ? CoordMax : qx_ff[CoordWidth-1:0];
   assign clamp_y = (qy_ff[SumWidth-1:CoordWidth] != '0) ? CoordMax : qy_ff[CoordWidth-1:0];

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         StIdle: begin
            if (q_valid) begin
               state_in = StRun;
               step_in  = '0;
            end
         end
         StRun: begin
            step_in = step_ff + 1'b1;
            if (step_ff == StepWidth'(DivSteps - 1)) begin
               state_in = StDone;
            end
         end
         StDone: begin
            if (load_out) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         div_ff <= q_rec.hit_count;
         qx_ff  <= q_rec.col_sum;
         qy_ff  <= q_rec.row_sum;
         rx_ff  <= '0;
         ry_ff  <= '0;
      end else if (state_ff == StRun) begin
         qx_ff <= {qx_ff[SumWidth-2:0], bit_x};
         qy_ff <= {qy_ff[SumWidth-2:0], bit_y};
         rx_ff <= rem_x;
         ry_ff <= rem_y;
      end
      if (load_out) begin
         ox_ff <= clamp_x;
         oy_ff <= clamp_y;
         on_ff <= div_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_centroid_x = ox_ff;
   assign rsp_centroid_y = oy_ff;
   assign rsp_hit_count  = on_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StRun) |-> (div_ff != '0))
      else $error("dpc_divider: zero divisor");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StRun) |-> (rx_ff < div_ff) && (ry_ff < div_ff))
      else $error("dpc_divider: partial remainder out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit_count != '0))
      else $error("dpc_divider: zero count reported");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StDone) && !load_out |=> (state_ff == StDone))
      else $error("dpc_divider: finished result dropped");

endmodule

// ===== rtl/dark_pixel_centroid_core.sv =====
// ---------------------------------------------------------------------------
// dark_pixel_centroid_core
// Centroid of dark pixels in a raster BGR stream.
// ---------------------------------------------------------------------------
// Takes one pixel per clock. A pixel whose blue+green+red is below the
// threshold register (reset 240) adds to a count and to column and row sums;
// position is tracked from the line-end and frame-end marks and saturates at
// the last column and row. The pixel carrying frame end closes the frame and
// gives one result word: truncated mean column, truncated mean row (each
// clamped to 2047) and the count, reported as 1 for an empty frame. A frame
// record goes through a two-entry queue to a pair of restoring dividers
// that produce one quotient bit per clock; each result waits in an output
// register for rsp_ready. Pixels keep flowing during the division;
// req_ready drops only while two frame records wait in the queue.
module dark_pixel_centroid_core
   import dpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [ThrWidth-1:0]   csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PixWidth-1:0]   req_blue,
   input  logic [PixWidth-1:0]   req_green,
   input  logic [PixWidth-1:0]   req_red,
   input  logic                  req_line_end,
   input  logic                  req_frame_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CoordWidth-1:0] rsp_centroid_x,
   output logic [CoordWidth-1:0] rsp_centroid_y,
   output logic [TallyWidth-1:0] rsp_hit_count
);

   logic          q_full, q_push, q_valid, q_pop;
   frame_rec_type push_rec, pop_rec;

   dpc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_blue         (req_blue),
      .req_green        (req_green),
      .req_red          (req_red),
      .req_line_end     (req_line_end),
      .req_frame_end    (req_frame_end),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_rec            (push_rec)
   );

   dpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_rec  (push_rec),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop       (q_pop),
      .pop_rec   (pop_rec)
   );

   dpc_divider u_divider (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_rec          (pop_rec),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_centroid_x (rsp_centroid_x),
      .rsp_centroid_y (rsp_centroid_y),
      .rsp_hit_count  (rsp_hit_count)
   );

endmodule
